/* hw/rtl/imu_frame_parser_filter_top_defines.svh */
// ----------------------------------------------------------------------------
// IMU frame parser assertion macros
// Shorthand for clocked implication checks, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IMU_FRAME_PARSER_FILTER_TOP_DEFINES_SVH
`define IMU_FRAME_PARSER_FILTER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define FPF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imu frame parser check failed");
// next-cycle implication
`define FPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imu frame parser check failed");
`else
`define FPF_ASSERT_SAME(lbl, ante, cons)
`define FPF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/imu_fpf_pkg.sv */
// ----------------------------------------------------------------------------
// IMU frame parser package
// Word types, frame layout constants and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package imu_fpf_pkg;

  localparam int FRAME_DEPTH = 47;
  localparam int IDX_W       = 6;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        online;
    logic [31:0] accel_x;
    logic [31:0] accel_y;
    logic [31:0] accel_z;
    logic [31:0] gyro_y;
    logic [31:0] gyro_z;
    logic [31:0] yaw_raw;
    logic [31:0] roll_smoothed;
    logic [31:0] pitch_smoothed;
    logic [31:0] rate_smoothed;
    logic [31:0] rate_change_smoothed;
  } out_word_t;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HDR2    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'd0,
    SQ_FETCH = 4'd1,
    SQ_DRAIN = 4'd2,
    SQ_DIFF  = 4'd3,
    SQ_MLO   = 4'd4,
    SQ_MHI   = 4'd5,
    SQ_RND   = 4'd6,
    SQ_UPD   = 4'd7,
    SQ_DXD   = 4'd8,
    SQ_DXS   = 4'd9,
    SQ_OUT   = 4'd10
  } seq_state_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [2:0] STAT_OK   = 3'd0;
  localparam logic [2:0] STAT_CSUM = 3'd1;
  localparam logic [2:0] STAT_ID   = 3'd2;
  localparam logic [2:0] STAT_LEN  = 3'd3;
  localparam logic [2:0] STAT_TICK = 3'd4;

  localparam logic [1:0] CFG_GAIN  = 2'd0;
  localparam logic [1:0] CFG_RATE  = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  localparam logic [7:0] HDR_FIRST  = 8'h59;
  localparam logic [7:0] HDR_SECOND = 8'h53;
  localparam logic [7:0] ID_ACC     = 8'h10;
  localparam logic [7:0] ID_GYRO    = 8'h20;
  localparam logic [7:0] ID_ANGLE   = 8'h40;
  localparam logic [7:0] FRAME_LEN  = 8'h2A;
  localparam logic [7:0] BLOCK_LEN  = 8'h0C;

  // byte positions inside the frame
  localparam logic [IDX_W-1:0] POS_FIRST     = 6'd2;
  localparam logic [IDX_W-1:0] POS_LEN       = 6'd4;
  localparam logic [IDX_W-1:0] POS_ACC_ID    = 6'd5;
  localparam logic [IDX_W-1:0] POS_ACC_LEN   = 6'd6;
  localparam logic [IDX_W-1:0] POS_GYRO_ID   = 6'd19;
  localparam logic [IDX_W-1:0] POS_GYRO_LEN  = 6'd20;
  localparam logic [IDX_W-1:0] POS_ANGLE_ID  = 6'd33;
  localparam logic [IDX_W-1:0] POS_ANGLE_LEN = 6'd34;
  localparam logic [IDX_W-1:0] POS_CHK_A     = 6'd47;
  localparam logic [IDX_W-1:0] POS_CHK_B     = 6'd48;

  // fetched words, in fetch order
  localparam int NUM_WORDS = 9;
  localparam logic [3:0] W_GX    = 4'd3;
  localparam logic [3:0] W_PITCH = 4'd6;
  localparam logic [3:0] W_ROLL  = 4'd7;
  localparam logic [5:0] FETCH_LAST = 6'd35;

  // filter slots
  localparam logic [1:0] F_ROLL  = 2'd0;
  localparam logic [1:0] F_PITCH = 2'd1;
  localparam logic [1:0] F_RCHG  = 2'd2;
  localparam logic [1:0] F_RATE  = 2'd3;

  localparam logic [31:0] FILT_RESET = 32'd1000000;

  // first byte address of each fetched little-endian word
  function automatic logic [IDX_W-1:0] fetch_base(input logic [3:0] w);
    logic [IDX_W-1:0] a;
    case (w)
      4'd0:    a = 6'd7;
      4'd1:    a = 6'd11;
      4'd2:    a = 6'd15;
      4'd3:    a = 6'd21;
      4'd4:    a = 6'd25;
      4'd5:    a = 6'd29;
      4'd6:    a = 6'd35;
      4'd7:    a = 6'd39;
      4'd8:    a = 6'd43;
      default: a = 6'd7;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/imu_frame_parser_filter_top.sv */
// ----------------------------------------------------------------------------
// IMU frame parser and smoothing filter
// Parses 49-byte sensor frames from a UART byte stream and filters angles and gyro rate.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries one item per handshake: a received byte (op 0) or a
//   poll tick (op 1). out_word carries one result per tick and per frame
//   end. Both channels move a word at an edge with valid high, stall low.
//   Configuration writes go through cfg_we/cfg_index/cfg_wdata while idle.
// Results and sequencing:
//   A byte gives no result, except the last byte of a frame. A tick, or a
//   frame that fails its checks, gives its result in the cycle after it is
//   taken. After the last byte of a good frame come 36 reads of the frame
//   RAM (one byte per cycle, single read port) and a drain step, then one
//   shared 23x18 multiplier runs the derivative and the four filters, then
//   an output step. Input stalls during that sequence.
// Reset:
//   rst_n low clears the parser to hunting, the filters to 1000000, the
//   online flag, and restores the register defaults. The frame RAM keeps
//   old bytes; every frame rewrites the bytes that it reads.
// Receiver stall:
//   A result waits in the output register; while the receiver stalls it,
//   input stalls too, whether or not the next word gives a result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "imu_frame_parser_filter_top_defines.svh"

module imu_frame_parser_filter_top
  import imu_fpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // configuration
  logic [15:0] gain_r;
  logic [9:0]  rate_scale_r;
  logic [7:0]  limit_r;

  // parser state
  phase_t           phase_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       sum_a_r;
  logic [7:0]       sum_b_r;
  logic             id_bad_r;
  logic             len_bad_r;
  logic [7:0]       poll_r;
  logic             online_r;

  // filter sequencer
  seq_state_t       seq_r;
  seq_state_t       seq_nxt;
  logic [5:0]       fc_r;
  logic             rd_vld_r;
  logic [5:0]       rd_cnt_r;
  logic [23:0]      word_sh_r;
  logic [31:0]      word_r [NUM_WORDS];
  logic [1:0]       f_r;
  logic             dx_mode_r;
  logic [43:0]      d_r;
  logic [43:0]      dx_r;
  logic [40:0]      p_lo_r;
  logic [40:0]      p_hi_r;
  logic [46:0]      rnd_r;
  logic [31:0]      st_r [4];

  // output register
  logic             out_valid_r;
  out_word_t        out_word_r;

  // RAM port
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;

  logic             in_acc;
  logic             slot_free;
  logic             is_byte;
  logic             is_tick;
  logic [7:0]       b;
  logic [7:0]       sum_a_inc;
  logic             end_byte;
  logic             csum_bad;
  logic             frame_good;
  logic [7:0]       poll_inc;
  logic             poll_over;
  logic [8:0]       lim_sum;

  logic signed [22:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [40:0] mul_p;
  logic [61:0]        prod_sum;
  logic [61:0]        rnd_sum;
  logic [43:0]        x_sel;
  logic [31:0]        s_sel;
  logic [47:0]        upd_sum;
  logic [31:0]        upd_sat;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  // The output register is free at an edge when it is empty or being taken.
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (seq_r != SQ_IDLE) || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign b        = in_word.data_byte;
  assign is_tick  = in_acc && (in_word.op == OP_TICK);
  assign is_byte  = in_acc && (in_word.op == OP_BYTE);
  assign end_byte = is_byte && (phase_r == PH_COLLECT) && (idx_r == POS_CHK_B);

  // Fletcher pair: the first check byte is folded into sum_a, so a good
  // frame leaves sum_a at zero and sum_b equal to the second check byte.
  assign sum_a_inc  = sum_a_r + b;
  assign csum_bad   = (sum_a_r != 8'd0) || (sum_b_r != b);
  assign frame_good = end_byte && !csum_bad && !id_bad_r && !len_bad_r;

  // Poll aging: saturating count, then fall back to limit + 10.
  assign poll_inc  = (poll_r != 8'hFF) ? poll_r + 8'd1 : 8'hFF;
  assign poll_over = poll_inc > limit_r;
  assign lim_sum   = {1'b0, limit_r} + 9'd10;

  // --------------------------------------------------------------------------
  // Frame RAM: bytes 2..46 of the current frame
  // --------------------------------------------------------------------------
  assign ram_we    = is_byte && (phase_r == PH_COLLECT) && (idx_r < POS_CHK_A);
  assign ram_raddr = fetch_base(fc_r[5:2]) + {4'd0, fc_r[1:0]};

  imu_fpf_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (b),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= 16'd32440;
      rate_scale_r <= 10'd50;
      limit_r      <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:  gain_r       <= cfg_wdata;
        CFG_RATE:  rate_scale_r <= cfg_wdata[9:0];
        CFG_LIMIT: limit_r      <= cfg_wdata[7:0];
        default:   ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Byte parser, tick aging and online flag
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      idx_r     <= '0;
      sum_a_r   <= '0;
      sum_b_r   <= '0;
      id_bad_r  <= 1'b0;
      len_bad_r <= 1'b0;
      poll_r    <= 8'd1;
      online_r  <= 1'b0;
    end else begin
      if (is_tick) begin
        if (poll_over) begin
          poll_r   <= lim_sum[8] ? 8'hFF : lim_sum[7:0];
          online_r <= 1'b0;
        end else begin
          poll_r <= poll_inc;
        end
      end else if (is_byte) begin
        case (phase_r)
          PH_HDR2: begin
            if (b == HDR_SECOND) begin
              phase_r   <= PH_COLLECT;
              idx_r     <= POS_FIRST;
              sum_a_r   <= '0;
              sum_b_r   <= '0;
              id_bad_r  <= 1'b0;
              len_bad_r <= 1'b0;
            end else if (b != HDR_FIRST) begin
              phase_r <= PH_HUNT;
            end
          end
          PH_COLLECT: begin
            if (idx_r < POS_CHK_A) begin
              sum_a_r <= sum_a_inc;
              sum_b_r <= sum_b_r + sum_a_inc;
              idx_r   <= idx_r + 6'd1;
              // check ids and lengths on the fly
              case (idx_r)
                POS_LEN:       if (b != FRAME_LEN) len_bad_r <= 1'b1;
                POS_ACC_ID:    if (b != ID_ACC)    id_bad_r  <= 1'b1;
                POS_ACC_LEN:   if (b != BLOCK_LEN) len_bad_r <= 1'b1;
                POS_GYRO_ID:   if (b != ID_GYRO)   id_bad_r  <= 1'b1;
                POS_GYRO_LEN:  if (b != BLOCK_LEN) len_bad_r <= 1'b1;
                POS_ANGLE_ID:  if (b != ID_ANGLE)  id_bad_r  <= 1'b1;
                POS_ANGLE_LEN: if (b != BLOCK_LEN) len_bad_r <= 1'b1;
                default:       ;
              endcase
            end else if (idx_r == POS_CHK_A) begin
              sum_a_r <= sum_a_r ^ b;
              idx_r   <= idx_r + 6'd1;
            end else begin
              phase_r <= PH_HUNT;
              idx_r   <= '0;
            end
          end
          default: begin
            phase_r <= (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
          end
        endcase
      end
      // a good frame revives the link once its filters are done
      if (seq_r == SQ_OUT && slot_free) begin
        online_r <= 1'b1;
        poll_r   <= 8'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Filter sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SQ_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      SQ_IDLE:  if (frame_good) seq_nxt = SQ_FETCH;
      SQ_FETCH: if (fc_r == FETCH_LAST) seq_nxt = SQ_DRAIN;
      SQ_DRAIN: seq_nxt = SQ_DIFF;
      SQ_DIFF:  seq_nxt = SQ_MLO;
      SQ_MLO:   seq_nxt = SQ_MHI;
      SQ_MHI:   seq_nxt = dx_mode_r ? SQ_DXS : SQ_RND;
      SQ_RND:   seq_nxt = SQ_UPD;
      SQ_UPD: begin
        if (f_r == F_PITCH) begin
          seq_nxt = SQ_DXD;
        end else if (f_r == F_RATE) begin
          seq_nxt = SQ_OUT;
        end else begin
          seq_nxt = SQ_DIFF;
        end
      end
      SQ_DXD:   seq_nxt = SQ_MLO;
      SQ_DXS:   seq_nxt = SQ_DIFF;
      SQ_OUT:   if (slot_free) seq_nxt = SQ_IDLE;
      default:  seq_nxt = SQ_IDLE;
    endcase
  end

  // Shared multiplier: a 44-bit operand goes in two 22-bit halves.
  assign mul_a = (seq_r == SQ_MHI) ? $signed({d_r[43], d_r[43:22]})
                                   : $signed({1'b0, d_r[21:0]});
  assign mul_b = dx_mode_r ? $signed({8'd0, rate_scale_r}) : $signed({2'd0, gain_r});
  assign mul_p = mul_a * mul_b;

  assign prod_sum = ({{21{p_hi_r[40]}}, p_hi_r} << 22) + {{21{p_lo_r[40]}}, p_lo_r};
  // round half up: floor((v + 2^14) / 2^15)
  assign rnd_sum  = prod_sum + 62'd16384;

  always_comb begin
    case (f_r)
      F_ROLL:  x_sel = {{12{word_r[W_ROLL][31]}}, word_r[W_ROLL]};
      F_PITCH: x_sel = {{12{word_r[W_PITCH][31]}}, word_r[W_PITCH]};
      F_RCHG:  x_sel = dx_r;
      default: x_sel = {{12{word_r[W_GX][31]}}, word_r[W_GX]};
    endcase
  end

  assign s_sel   = st_r[f_r];
  assign upd_sum = {{16{s_sel[31]}}, s_sel} + {rnd_r[46], rnd_r};

  always_comb begin
    if (upd_sum[47:31] == {17{upd_sum[47]}}) begin
      upd_sat = upd_sum[31:0];
    end else if (upd_sum[47]) begin
      upd_sat = 32'h8000_0000;
    end else begin
      upd_sat = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r      <= '0;
      rd_vld_r  <= 1'b0;
      f_r       <= F_ROLL;
      dx_mode_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        st_r[k] <= FILT_RESET;
      end
    end else begin
      rd_vld_r <= (seq_r == SQ_FETCH);
      rd_cnt_r <= fc_r;
      // assemble little-endian words as bytes return from the RAM
      if (rd_vld_r) begin
        word_sh_r <= {ram_rdata, word_sh_r[23:8]};
        if (rd_cnt_r[1:0] == 2'd3) begin
          word_r[rd_cnt_r[5:2]] <= {ram_rdata, word_sh_r};
        end
      end
      case (seq_r)
        SQ_IDLE: begin
          fc_r      <= '0;
          f_r       <= F_ROLL;
          dx_mode_r <= 1'b0;
        end
        SQ_FETCH: fc_r   <= fc_r + 6'd1;
        SQ_DIFF:  d_r    <= x_sel - {{12{s_sel[31]}}, s_sel};
        SQ_MLO:   p_lo_r <= mul_p;
        SQ_MHI:   p_hi_r <= mul_p;
        SQ_RND:   rnd_r  <= rnd_sum[61:15];
        SQ_UPD: begin
          st_r[f_r] <= upd_sat;
          f_r       <= f_r + 2'd1;
        end
        SQ_DXD: begin
          // derivative input uses the rate state before its update
          d_r       <= {{12{word_r[W_GX][31]}}, word_r[W_GX]}
                     - {{12{st_r[F_RATE][31]}}, st_r[F_RATE]};
          dx_mode_r <= 1'b1;
        end
        SQ_DXS: begin
          dx_r      <= prod_sum[43:0];
          dx_mode_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (is_tick || (end_byte && !frame_good)) begin
      out_valid_r <= 1'b1;
    end else if (seq_r == SQ_OUT && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick || (end_byte && !frame_good)) begin
      if (is_tick) begin
        out_word_r.status <= STAT_TICK;
        out_word_r.online <= poll_over ? 1'b0 : online_r;
      end else begin
        if (csum_bad) begin
          out_word_r.status <= STAT_CSUM;
        end else if (id_bad_r) begin
          out_word_r.status <= STAT_ID;
        end else begin
          out_word_r.status <= STAT_LEN;
        end
        out_word_r.online <= online_r;
      end
      out_word_r.accel_x <= '0;
      out_word_r.accel_y <= '0;
      out_word_r.accel_z <= '0;
      out_word_r.gyro_y  <= '0;
      out_word_r.gyro_z  <= '0;
      out_word_r.yaw_raw <= '0;
      out_word_r.roll_smoothed        <= st_r[F_ROLL];
      out_word_r.pitch_smoothed       <= st_r[F_PITCH];
      out_word_r.rate_smoothed        <= st_r[F_RATE];
      out_word_r.rate_change_smoothed <= st_r[F_RCHG];
    end else if (seq_r == SQ_OUT && slot_free) begin
      out_word_r.status  <= STAT_OK;
      out_word_r.online  <= 1'b1;
      out_word_r.accel_x <= word_r[0];
      out_word_r.accel_y <= word_r[1];
      out_word_r.accel_z <= word_r[2];
      out_word_r.gyro_y  <= word_r[4];
      out_word_r.gyro_z  <= word_r[5];
      out_word_r.yaw_raw <= word_r[8];
      out_word_r.roll_smoothed        <= st_r[F_ROLL];
      out_word_r.pitch_smoothed       <= st_r[F_PITCH];
      out_word_r.rate_smoothed        <= st_r[F_RATE];
      out_word_r.rate_change_smoothed <= st_r[F_RCHG];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FPF_ASSERT_NEXT(a_good_frame_starts_seq, frame_good, seq_r == SQ_FETCH)
  `FPF_ASSERT_NEXT(a_tick_reports, is_tick, out_valid_r && out_word_r.status == STAT_TICK)
  `FPF_ASSERT_NEXT(a_seq_out_ok, seq_r == SQ_OUT && slot_free,
                   out_valid_r && out_word_r.status == STAT_OK && out_word_r.online)
  `FPF_ASSERT_SAME(a_idx_range, phase_r == PH_COLLECT,
                   idx_r >= POS_FIRST && idx_r <= POS_CHK_B)
  `FPF_ASSERT_SAME(a_fetch_range, seq_r == SQ_FETCH, fc_r <= FETCH_LAST)

endmodule

`default_nettype wire

/* hw/rtl/imu_fpf_ram.sv */
// ----------------------------------------------------------------------------
// IMU frame parser RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_fpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 47
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* verif/imu_fpf_predict_check.sv */
// ----------------------------------------------------------------------------
// IMU frame parser result check
// Tracks parser, filter and online state from accepted input words and
// register writes, and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_fpf_predict_check
  import imu_fpf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire in_word_t    in_word,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire out_word_t   out_word,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  output int               fail_count,
  output int               outstanding
);

  // start of each little-endian value inside the frame
  localparam int ACC_X_AT  = 7;
  localparam int ACC_Y_AT  = 11;
  localparam int ACC_Z_AT  = 15;
  localparam int GYRO_X_AT = 21;
  localparam int GYRO_Y_AT = 25;
  localparam int GYRO_Z_AT = 29;
  localparam int PITCH_AT  = 35;
  localparam int ROLL_AT   = 39;
  localparam int YAW_AT    = 43;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  logic [15:0] gain_reg;
  logic [9:0]  rate_reg;
  logic [7:0]  limit_reg;

  phase_t      hunt_state;
  logic [5:0]  frame_pos;
  logic [7:0]  frame_mem [0:FRAME_DEPTH-1];
  logic [7:0]  run_a;
  logic [7:0]  run_b;
  int          roll_est;
  int          pitch_est;
  int          rate_est;
  int          rate_chg_est;
  logic [7:0]  tick_age;
  logic        link_up;

  out_word_t   result_q [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %08h want %08h", name, got, want));
  endtask

  function automatic int frame_word(input int at);
    return int'({frame_mem[at+3], frame_mem[at+2], frame_mem[at+1], frame_mem[at]});
  endfunction

  // s + round_half_up(g * (x - s) / 2^15), clamped to 32 bits
  function automatic int ema_update(input int s, input longint x);
    longint g;
    longint acc;
    g = gain_reg;
    acc = longint'(s) + ((g * (x - longint'(s)) + 64'sd16384) >>> 15);
    if (acc > S32_MAX) acc = S32_MAX;
    else if (acc < S32_MIN) acc = S32_MIN;
    return int'(acc);
  endfunction

  function automatic out_word_t status_report(input logic [2:0] code);
    out_word_t r;
    r = '0;
    r.status               = code;
    r.online               = link_up;
    r.roll_smoothed        = roll_est;
    r.pitch_smoothed       = pitch_est;
    r.rate_smoothed        = rate_est;
    r.rate_change_smoothed = rate_chg_est;
    return r;
  endfunction

  task automatic close_frame(input logic [7:0] last);
    out_word_t r;
    int        gx;
    longint    rs;
    longint    drive;
    if (run_a != 8'd0 || run_b != last) begin
      result_q.push_back(status_report(STAT_CSUM));
    end else if (frame_mem[POS_ACC_ID] != ID_ACC || frame_mem[POS_GYRO_ID] != ID_GYRO ||
                 frame_mem[POS_ANGLE_ID] != ID_ANGLE) begin
      result_q.push_back(status_report(STAT_ID));
    end else if (frame_mem[POS_LEN] != FRAME_LEN || frame_mem[POS_ACC_LEN] != BLOCK_LEN ||
                 frame_mem[POS_GYRO_LEN] != BLOCK_LEN ||
                 frame_mem[POS_ANGLE_LEN] != BLOCK_LEN) begin
      result_q.push_back(status_report(STAT_LEN));
    end else begin
      gx = frame_word(GYRO_X_AT);
      rs = rate_reg;
      roll_est  = ema_update(roll_est, frame_word(ROLL_AT));
      pitch_est = ema_update(pitch_est, frame_word(PITCH_AT));
      // derivative sees the rate state before the rate filter moves
      drive = (longint'(gx) - longint'(rate_est)) * rs;
      rate_chg_est = ema_update(rate_chg_est, drive);
      rate_est     = ema_update(rate_est, gx);
      link_up  = 1'b1;
      tick_age = 8'd1;
      r = status_report(STAT_OK);
      r.accel_x = frame_word(ACC_X_AT);
      r.accel_y = frame_word(ACC_Y_AT);
      r.accel_z = frame_word(ACC_Z_AT);
      r.gyro_y  = frame_word(GYRO_Y_AT);
      r.gyro_z  = frame_word(GYRO_Z_AT);
      r.yaw_raw = frame_word(YAW_AT);
      result_q.push_back(r);
    end
  endtask

  task automatic predict_word(input in_word_t w);
    logic [7:0] b;
    logic [8:0] lim;
    b = w.data_byte;
    if (w.op == OP_TICK) begin
      if (tick_age != 8'd255) tick_age = tick_age + 8'd1;
      if (tick_age > limit_reg) begin
        lim = {1'b0, limit_reg} + 9'd10;
        tick_age = (lim > 9'd255) ? 8'd255 : lim[7:0];
        link_up = 1'b0;
      end
      result_q.push_back(status_report(STAT_TICK));
    end else begin
      case (hunt_state)
        PH_HDR2: begin
          if (b == HDR_SECOND) begin
            hunt_state = PH_COLLECT;
            frame_pos  = POS_FIRST;
            run_a      = 8'd0;
            run_b      = 8'd0;
          end else if (b != HDR_FIRST) begin
            hunt_state = PH_HUNT;
          end
        end
        PH_COLLECT: begin
          if (frame_pos < POS_CHK_A) begin
            frame_mem[frame_pos] = b;
            run_a = run_a + b;
            run_b = run_b + run_a;
            frame_pos = frame_pos + 6'd1;
          end else if (frame_pos == POS_CHK_A) begin
            run_a = run_a ^ b;
            frame_pos = frame_pos + 6'd1;
          end else begin
            hunt_state = PH_HUNT;
            frame_pos  = 6'd0;
            close_frame(b);
          end
        end
        default: begin
          hunt_state = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      gain_reg     = 16'd32440;
      rate_reg     = 10'd50;
      limit_reg    = 8'd10;
      hunt_state   = PH_HUNT;
      frame_pos    = 6'd0;
      run_a        = 8'd0;
      run_b        = 8'd0;
      roll_est     = FILT_RESET;
      pitch_est    = FILT_RESET;
      rate_est     = FILT_RESET;
      rate_chg_est = FILT_RESET;
      tick_age     = 8'd1;
      link_up      = 1'b0;
      result_q.delete();
      fail_count   = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:  gain_reg  = cfg_wdata;
          CFG_RATE:  rate_reg  = cfg_wdata[9:0];
          CFG_LIMIT: limit_reg = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %0d", out_word.status));
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(out_word.status), 32'(want.status));
          check_field("online", 32'(out_word.online), 32'(want.online));
          check_field("accel_x", out_word.accel_x, want.accel_x);
          check_field("accel_y", out_word.accel_y, want.accel_y);
          check_field("accel_z", out_word.accel_z, want.accel_z);
          check_field("gyro_y", out_word.gyro_y, want.gyro_y);
          check_field("gyro_z", out_word.gyro_z, want.gyro_z);
          check_field("yaw_raw", out_word.yaw_raw, want.yaw_raw);
          check_field("roll_smoothed", out_word.roll_smoothed, want.roll_smoothed);
          check_field("pitch_smoothed", out_word.pitch_smoothed, want.pitch_smoothed);
          check_field("rate_smoothed", out_word.rate_smoothed, want.rate_smoothed);
          check_field("rate_change_smoothed", out_word.rate_change_smoothed,
                      want.rate_change_smoothed);
        end
      end
      if (in_valid && !in_stall) predict_word(in_word);
      outstanding <= result_q.size();
    end
  end

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// IMU frame parser testbench
// Feeds byte and tick words with random gaps against a random result stall,
// across several register settings, while a separate check module predicts
// and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import imu_fpf_pkg::*;

  // settle time, with margin over a good frame's filter sequence
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASE_ITEMS   = 130;
  localparam int FRAME_BYTES   = 49;
  localparam int IDLE_PCT      = 22;

  typedef enum int {
    FR_GOOD,
    FR_BAD_SUM,
    FR_BAD_ID,
    FR_BAD_LEN,
    FR_SUM_AND_ID,
    FR_ID_AND_LEN
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int          fail_count;
  int          outstanding;
  int          sent;
  bit          calm;
  logic [7:0]  frm [0:FRAME_BYTES-1];

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  imu_frame_parser_filter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  imu_fpf_predict_check frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver back-pressure: stall at random, never during the calm stretch.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

  // Offer one word: idle a random number of cycles first, then hold the
  // word until an edge with stall low takes it.
  task automatic send_word(input logic op_code, input logic [7:0] b);
    in_word_t w;
    w.op        = op_code;
    w.data_byte = b;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // A mix of full-range random values, realistic magnitudes and the 32-bit extremes.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4, 5:    return $urandom_range(0, 4000000) - 32'd2000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic frame_kind_t pick_kind();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return FR_GOOD;
    if (p < 75) return FR_BAD_SUM;
    if (p < 83) return FR_BAD_ID;
    if (p < 91) return FR_BAD_LEN;
    if (p < 95) return FR_SUM_AND_ID;
    return FR_ID_AND_LEN;
  endfunction

  // Assemble a frame into frm. Id and length damage goes in before the
  // check bytes are computed, so only the intended check trips; checksum
  // damage goes in afterward.
  task automatic build_frame(input frame_kind_t kind, input bit fixed,
                             input logic [31:0] fix_val);
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [31:0] v;
    int          base;
    int          p;
    frm[0]             = HDR_FIRST;
    frm[1]             = HDR_SECOND;
    frm[2]             = 8'($urandom());
    frm[3]             = 8'($urandom());
    frm[POS_LEN]       = FRAME_LEN;
    frm[POS_ACC_ID]    = ID_ACC;
    frm[POS_ACC_LEN]   = BLOCK_LEN;
    frm[POS_GYRO_ID]   = ID_GYRO;
    frm[POS_GYRO_LEN]  = BLOCK_LEN;
    frm[POS_ANGLE_ID]  = ID_ANGLE;
    frm[POS_ANGLE_LEN] = BLOCK_LEN;
    // nine little-endian values, three per block, skipping id/len pairs
    for (int k = 0; k < 9; k++) begin
      base = 7 + 4 * k + 2 * (k / 3);
      v = fixed ? fix_val : pick_value();
      for (int j = 0; j < 4; j++) frm[base + j] = v[8*j +: 8];
    end
    if (kind == FR_BAD_ID || kind == FR_SUM_AND_ID || kind == FR_ID_AND_LEN) begin
      case ($urandom_range(0, 2))
        0:       p = POS_ACC_ID;
        1:       p = POS_GYRO_ID;
        default: p = POS_ANGLE_ID;
      endcase
      frm[p] = frm[p] ^ 8'($urandom_range(1, 255));
    end
    if (kind == FR_BAD_LEN || kind == FR_ID_AND_LEN) begin
      case ($urandom_range(0, 3))
        0:       p = POS_LEN;
        1:       p = POS_ACC_LEN;
        2:       p = POS_GYRO_LEN;
        default: p = POS_ANGLE_LEN;
      endcase
      frm[p] = frm[p] ^ 8'($urandom_range(1, 255));
    end
    sa = 8'd0;
    sb = 8'd0;
    for (int i = POS_FIRST; i < POS_CHK_A; i++) begin
      sa = sa + frm[i];
      sb = sb + sa;
    end
    frm[POS_CHK_A] = sa;
    frm[POS_CHK_B] = sb;
    if (kind == FR_BAD_SUM || kind == FR_SUM_AND_ID) begin
      p = $urandom_range(POS_FIRST, POS_CHK_B);
      frm[p] = frm[p] ^ 8'($urandom_range(1, 255));
    end
  endtask

  // Send a frame; now and then slip a tick in between its bytes, which
  // must not disturb the parse.
  task automatic send_frame(input frame_kind_t kind, input bit fixed,
                            input logic [31:0] fix_val);
    build_frame(kind, fixed, fix_val);
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i > 1 && $urandom_range(0, 99) < 2) send_word(OP_TICK, 8'($urandom()));
      send_word(OP_BYTE, frm[i]);
    end
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_word(OP_TICK, 8'($urandom()));
  endtask

  // Lone first header byte, then either a junk byte (back to hunting) or
  // nothing, so the frame's own 0x59 counts as a fresh first header byte.
  task automatic send_broken_header();
    logic [7:0] b;
    send_word(OP_BYTE, HDR_FIRST);
    if ($urandom_range(0, 1) == 0) begin
      do b = 8'($urandom()); while (b == HDR_FIRST || b == HDR_SECOND);
      send_word(OP_BYTE, b);
    end
    send_frame(pick_kind(), 1'b0, 32'd0);
  endtask

  // Quiesce the block, then write all three registers back to back.
  task automatic set_config(input logic [15:0] gain, input logic [15:0] rate,
                            input logic [15:0] limit);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_index <= CFG_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: mostly frames with random content, most well-formed and
  // some damaged, plus broken headers, tick bursts and header-free noise.
  task automatic random_phase(input int budget);
    int         stop_at;
    int         pick;
    logic [7:0] b;
    stop_at = sent + budget;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(pick_kind(), 1'b0, 32'd0);
      end else if (pick < 73) begin
        send_broken_header();
      end else if (pick < 88) begin
        send_ticks($urandom_range(1, 4));
      end else if (pick < 97) begin
        // noise stays clear of the first header byte, so the parser is
        // back in hunting when the next frame starts
        repeat ($urandom_range(1, 6)) begin
          do b = 8'($urandom()); while (b == HDR_FIRST);
          send_word(OP_BYTE, b);
        end
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_GAIN;
    cfg_wdata <= '0;
    calm = 1'b0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: offline tick, value extremes, each failing check alone
    // and in pairs to pin the check order, both broken-header forms, and
    // enough ticks to age the online flag out at the default limit.
    send_ticks(1);
    send_frame(FR_GOOD, 1'b1, 32'h0000_0000);
    send_frame(FR_GOOD, 1'b1, 32'h7fff_ffff);
    send_frame(FR_GOOD, 1'b1, 32'h8000_0000);
    send_frame(FR_GOOD, 1'b1, 32'hffff_ffff);
    send_frame(FR_BAD_SUM, 1'b0, 32'd0);
    send_frame(FR_BAD_ID, 1'b0, 32'd0);
    send_frame(FR_BAD_LEN, 1'b0, 32'd0);
    send_frame(FR_SUM_AND_ID, 1'b0, 32'd0);
    send_frame(FR_ID_AND_LEN, 1'b0, 32'd0);
    send_word(OP_BYTE, HDR_FIRST);
    send_word(OP_BYTE, 8'h00);
    send_frame(FR_GOOD, 1'b0, 32'd0);
    send_word(OP_BYTE, HDR_FIRST);
    send_frame(FR_GOOD, 1'b0, 32'd0);
    send_ticks(12);

    random_phase(PHASE_ITEMS);

    // low end of every register
    set_config(16'd0, 16'd1, 16'd1);
    random_phase(PHASE_ITEMS);

    // high end; a long tick run drives the aging count into saturation
    set_config(16'd32768, 16'd1000, 16'd255);
    send_frame(FR_GOOD, 1'b0, 32'd0);
    send_ticks(260);
    random_phase(PHASE_ITEMS);

    // gain past unity, zero derivative scale, zero offline limit
    set_config(16'hffff, 16'd0, 16'd0);
    send_frame(FR_GOOD, 1'b1, 32'h7fff_ffff);
    send_frame(FR_GOOD, 1'b1, 32'h8000_0000);
    random_phase(PHASE_ITEMS);

    // random in-range setting, run with no idling on either side
    set_config(16'($urandom_range(0, 32768)), 16'($urandom_range(1, 1000)),
               16'($urandom_range(1, 255)));
    calm = 1'b1;
    random_phase(PHASE_ITEMS);
    calm = 1'b0;

    // full-width rate scale with a short offline limit
    set_config(16'd16384, 16'd1023, 16'd3);
    random_phase(PHASE_ITEMS);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hw/rtl
hw/rtl/imu_fpf_pkg.sv
hw/rtl/imu_fpf_ram.sv
hw/rtl/imu_frame_parser_filter_top.sv
verif/imu_fpf_predict_check.sv
verif/tb.sv
